[src/mcss_pkg.sv]
// Shared constants, codes and control types for the Markov chain state sampler.
package mcss_pkg;

    localparam int MAX_STATES     = 16;
    localparam int PROB_FRAC_BITS = 16;

    localparam int IDX_W     = $clog2(MAX_STATES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int PROB_W    = PROB_FRAC_BITS + 1;
    localparam int UNI_W     = PROB_FRAC_BITS;
    localparam int SUM_W     = PROB_W + IDX_W;
    localparam int TBL_DEPTH = MAX_STATES * MAX_STATES;
    localparam int TBL_AW    = 2 * IDX_W;

    localparam int NUM_W     = 5;
    localparam int MIN_STATES = 2;
    localparam int NUM_RESET = 2;

    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_SET  = 2'd1,
        OP_STEP = 2'd2,
        OP_RSVD = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic set;
        logic other;
        logic start;
        logic walk;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic walk_done;
    } ctrl_stat_t;

endpackage

[src/mcss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mcss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/mcss_ctrl.sv]
// Controller state machine: accepts transfers and sequences the row walk.
module mcss_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [mcss_pkg::OP_W-1:0] op,
    input  logic                  m_tready,
    input  mcss_pkg::ctrl_stat_t  stat,
    output mcss_pkg::ctrl_cmd_t   cmd
);

    import mcss_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    op_t    op_code;

    assign op_code = op_t'(op);
    assign s_tready = (state_reg == ST_IDLE) && (!stat.out_busy || m_tready);
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op_code == OP_STEP)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load  = accept && op_code == OP_LOAD;
                cmd.set   = accept && op_code == OP_SET;
                cmd.start = accept && op_code == OP_STEP;
                cmd.other = accept && op_code == OP_RSVD;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/mcss_datapath.sv]
// Datapath: state count, current state, transition table, running sum, output register.
module mcss_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mcss_pkg::ctrl_cmd_t               cmd,
    output mcss_pkg::ctrl_stat_t              stat,
    input  logic [mcss_pkg::IDX_W-1:0]        row,
    input  logic [mcss_pkg::IDX_W-1:0]        col,
    input  logic [mcss_pkg::PROB_W-1:0]       probability,
    input  logic [mcss_pkg::IDX_W-1:0]        new_state,
    input  logic [mcss_pkg::UNI_W-1:0]        uniform_value,
    input  logic                              cfg_we,
    input  logic [mcss_pkg::NUM_W-1:0]        cfg_wdata,
    output logic [mcss_pkg::NUM_W-1:0]        num_states,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [mcss_pkg::IDX_W-1:0]        current_state,
    output logic                              error
);

    import mcss_pkg::*;

    localparam logic [CNT_W-1:0] N_MIN = CNT_W'(MIN_STATES);
    localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_STATES);

    logic [NUM_W-1:0]  num_states_reg, num_states_next;
    logic [IDX_W-1:0]  present_reg, present_next;
    logic [UNI_W-1:0]  uni_reg, uni_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [IDX_W-1:0]  rd_col_reg, rd_col_next;
    logic [IDX_W-1:0]  acc_col_reg, acc_col_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_state_reg, out_state_next;
    logic              out_err_reg, out_err_next;

    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  num_ext;
    logic [IDX_W-1:0]  last_col;
    logic              load_bad, set_bad;
    logic [PROB_W-1:0] rd_data;
    logic [SUM_W-1:0]  sum_new;
    logic              hit, done;
    logic [IDX_W-1:0]  pick;

    // clamp the state count into [2, MAX_STATES]
    assign num_ext = CNT_W'(num_states_reg);
    always_comb
    begin
        if (num_ext < N_MIN)
        begin
            n_eff = N_MIN;
        end
        else if (num_ext > N_MAX)
        begin
            n_eff = N_MAX;
        end
        else
        begin
            n_eff = num_ext;
        end
    end

    assign last_col = IDX_W'(n_eff - CNT_W'(1));
    assign load_bad = (CNT_W'(row) >= n_eff) || (CNT_W'(col) >= n_eff);
    assign set_bad  = CNT_W'(new_state) >= n_eff;

    mcss_ram #(
        .WIDTH (PROB_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load && !load_bad),
        .waddr ({row, col}),
        .wdata (probability),
        .re    (cmd.walk),
        .raddr ({present_reg, rd_col_reg}),
        .rdata (rd_data)
    );

    assign sum_new = sum_reg + SUM_W'(rd_data);
    assign hit     = SUM_W'(uni_reg) < sum_new;
    assign done    = cmd.walk && pend_reg && (hit || acc_col_reg == last_col);
    assign pick    = hit ? acc_col_reg : last_col;

    always_comb
    begin
        num_states_next = num_states_reg;
        present_next    = present_reg;
        uni_next        = uni_reg;
        sum_next        = sum_reg;
        rd_col_next     = rd_col_reg;
        acc_col_next    = acc_col_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_state_next  = out_state_reg;
        out_err_next    = out_err_reg;

        if (cfg_we)
        begin
            num_states_next = cfg_wdata;
        end

        if (cmd.set && !set_bad)
        begin
            present_next = new_state;
        end

        if (cmd.start)
        begin
            uni_next    = uniform_value;
            sum_next    = '0;
            rd_col_next = '0;
            pend_next   = 1'b0;
        end

        if (cmd.walk)
        begin
            rd_col_next  = rd_col_reg + IDX_W'(1);
            acc_col_next = rd_col_reg;
            pend_next    = 1'b1;
            if (pend_reg)
            begin
                sum_next = sum_new;
            end
        end

        if (done)
        begin
            present_next = pick;
        end

        if (cmd.load || cmd.set || cmd.other || done)
        begin
            out_valid_next = 1'b1;
            out_state_next = present_next;
            out_err_next   = (cmd.load && load_bad) || (cmd.set && set_bad);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg <= NUM_W'(NUM_RESET);
            present_reg    <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            num_states_reg <= num_states_next;
            present_reg    <= present_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        uni_reg       <= uni_next;
        sum_reg       <= sum_next;
        rd_col_reg    <= rd_col_next;
        acc_col_reg   <= acc_col_next;
        out_state_reg <= out_state_next;
        out_err_reg   <= out_err_next;
    end

    assign stat.out_busy  = out_valid_reg;
    assign stat.walk_done = done;
    assign num_states     = num_states_reg;
    assign m_tvalid       = out_valid_reg;
    assign current_state  = out_state_reg;
    assign error          = out_err_reg;

endmodule

[src/markov_chain_state_sampler.sv]
// Top level of the Markov chain state sampler: stream ports, APB register port.
//
//   channel  | signals                       | content
//   ---------+-------------------------------+----------------------------------------
//   s_       | tvalid tready tdata tuser     | op in tuser; load, set or step request
//   m_       | tvalid tready tdata tuser     | current state in tdata, error in tuser
//   apb      | psel penable pwrite paddr ... | num_states at byte address 0
//
// Load, set and the unused op finish in the accept cycle; the result is
// registered on the next edge. A step walks the current row one table read
// per cycle through the single read port, across the N states in use, and
// stops early when a column hits. One transfer is in flight at a time;
// s_tready drops while a step walks or a result waits behind a stalled m_tready.
// Reset clears the current state to 0 and num_states to 2; the table is not cleared.
module markov_chain_state_sampler (
    input  logic                                clk,
    input  logic                                rst_n,
    // [3:0] row, [7:4] col, [24:8] probability, [28:25] new_state,
    // [44:29] uniform_value, [47:45] zero
    input  logic [mcss_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] op
    input  logic [mcss_pkg::OP_W-1:0]           s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] current_state, [7:4] zero
    output logic [mcss_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // [0] error
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mcss_pkg::APB_AW-1:0]         paddr,
    input  logic [mcss_pkg::APB_DW-1:0]         pwdata,
    output logic [mcss_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    import mcss_pkg::*;

    localparam int ROW_LO  = 0;
    localparam int COL_LO  = ROW_LO + IDX_W;
    localparam int PROB_LO = COL_LO + IDX_W;
    localparam int NS_LO   = PROB_LO + PROB_W;
    localparam int UNI_LO  = NS_LO + IDX_W;

    ctrl_cmd_t        cmd;
    ctrl_stat_t       stat;
    logic             cfg_we;
    logic             reg_sel;
    logic [NUM_W-1:0] num_states;
    logic [IDX_W-1:0] current_state;
    logic             error;

    // register 0 at byte address 0; other word addresses read as zero
    assign reg_sel = !paddr[2];
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? APB_DW'(num_states) : '0;

    mcss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcss_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .row           (s_tdata[ROW_LO +: IDX_W]),
        .col           (s_tdata[COL_LO +: IDX_W]),
        .probability   (s_tdata[PROB_LO +: PROB_W]),
        .new_state     (s_tdata[NS_LO +: IDX_W]),
        .uniform_value (s_tdata[UNI_LO +: UNI_W]),
        .cfg_we        (cfg_we),
        .cfg_wdata     (pwdata[NUM_W-1:0]),
        .num_states    (num_states),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .current_state (current_state),
        .error         (error)
    );

    assign m_tdata = OUT_TDATA_W'(current_state);
    assign m_tuser = error;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the Markov chain state sampler: directed rows, table fill, random.
module tb_top;
    import mcss_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 2 * MAX_STATES + 4;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 112;

    typedef struct {
        op_t              op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [PROB_W-1:0] prob;
        logic [IDX_W-1:0] new_state;
        logic [UNI_W-1:0] uniform;
    } chain_req_t;

    typedef struct {
        logic [IDX_W-1:0] state;
        logic             err;
    } chain_res_t;

    typedef struct {
        logic [NUM_W-1:0]  states;
        op_t               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [PROB_W-1:0] prob;
        logic [IDX_W-1:0]  new_state;
        logic [UNI_W-1:0]  uniform;
        bit                typed;
        logic [IDX_W-1:0]  exp_state;
        logic              exp_err;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    logic [PROB_W-1:0] chain_table [MAX_STATES][MAX_STATES];
    logic [IDX_W-1:0]  chain_state = '0;
    logic [NUM_W-1:0]  states_cfg = NUM_W'(NUM_RESET);
    chain_res_t        pending_results [$];
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                hold_cycles = 0;
    bit                sender_pauses = 1'b1;
    bit                receiver_stalls = 1'b1;

    directed_row_t directed_rows [22] = '{
        '{2, OP_RSVD, 0, 0, 17'h00000, 0, 16'h0000, 1, 0, 0},
        '{2, OP_SET,  0, 0, 17'h00000, 1, 16'h0000, 1, 1, 0},
        '{2, OP_SET,  0, 0, 17'h00000, 15, 16'h0000, 1, 1, 1},
        '{2, OP_LOAD, 2, 0, 17'h08000, 0, 16'h0000, 1, 1, 1},
        '{2, OP_LOAD, 0, 15, 17'h08000, 0, 16'h0000, 1, 1, 1},
        '{2, OP_LOAD, 15, 15, 17'h1FFFF, 0, 16'h0000, 1, 1, 1},
        '{2, OP_LOAD, 0, 0, 17'h10000, 0, 16'h0000, 1, 1, 0},
        '{2, OP_LOAD, 0, 1, 17'h00000, 0, 16'h0000, 1, 1, 0},
        '{2, OP_LOAD, 1, 0, 17'h00000, 0, 16'h0000, 1, 1, 0},
        '{2, OP_LOAD, 1, 1, 17'h1FFFF, 0, 16'h0000, 1, 1, 0},
        '{2, OP_STEP, 0, 0, 17'h00000, 0, 16'h0000, 0, 0, 0},
        '{2, OP_SET,  0, 0, 17'h00000, 0, 16'h0000, 1, 0, 0},
        '{2, OP_STEP, 0, 0, 17'h00000, 0, 16'hFFFF, 0, 0, 0},
        '{2, OP_LOAD, 0, 0, 17'h00000, 0, 16'h0000, 1, 0, 0},
        '{2, OP_LOAD, 0, 1, 17'h00000, 0, 16'h0000, 1, 0, 0},
        '{2, OP_STEP, 0, 0, 17'h00000, 0, 16'h0000, 0, 0, 0},
        '{3, OP_LOAD, 2, 0, 17'h0FFFF, 0, 16'h0000, 1, 1, 0},
        '{3, OP_LOAD, 2, 1, 17'h00001, 0, 16'h0000, 1, 1, 0},
        '{3, OP_SET,  0, 0, 17'h00000, 2, 16'h0000, 1, 2, 0},
        '{2, OP_STEP, 0, 0, 17'h00000, 0, 16'hFFFF, 0, 0, 0},
        '{2, OP_LOAD, 1, 2, 17'h04000, 0, 16'h0000, 0, 0, 0},
        '{2, OP_RSVD, 15, 15, 17'h1FFFF, 15, 16'hFFFF, 0, 0, 0}
    };

    int phase_states [PHASES] = '{16, 2, 31, 0, 9, 1, 17, 3, 16, 12};

    markov_chain_state_sampler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    function automatic int states_in_use();
        int n;
        n = states_cfg;
        if (n < MIN_STATES)
            n = MIN_STATES;
        if (n > MAX_STATES)
            n = MAX_STATES;
        return n;
    endfunction

    // updates the shadow chain and returns the result the block must produce
    function automatic chain_res_t apply_request(input chain_req_t r);
        chain_res_t  res;
        int          n;
        logic [31:0] sum;
        logic [IDX_W-1:0] next;
        bit          hit;
        n = states_in_use();
        res.err = 1'b0;
        case (r.op)
            OP_LOAD:
            begin
                if (r.row >= n || r.col >= n)
                    res.err = 1'b1;
                else
                    chain_table[r.row][r.col] = r.prob;
            end
            OP_SET:
            begin
                if (r.new_state >= n)
                    res.err = 1'b1;
                else
                    chain_state = r.new_state;
            end
            OP_STEP:
            begin
                sum = '0;
                next = IDX_W'(n - 1);
                hit = 1'b0;
                for (int j = 0; j < n; j++)
                begin
                    if (!hit)
                    begin
                        sum = sum + chain_table[chain_state][j];
                        if (32'(r.uniform) < sum)
                        begin
                            next = IDX_W'(j);
                            hit = 1'b1;
                        end
                    end
                end
                chain_state = next;
            end
            default: ;
        endcase
        res.state = chain_state;
        return res;
    endfunction

    function automatic chain_req_t random_request();
        chain_req_t r;
        int kind;
        int n;
        n = states_in_use();
        kind = $urandom_range(0, 99);
        r.op = op_t'($urandom_range(0, 3));
        r.row = IDX_W'($urandom);
        r.col = IDX_W'($urandom);
        r.prob = PROB_W'($urandom);
        r.new_state = IDX_W'($urandom);
        r.uniform = UNI_W'($urandom);
        if (kind < 50)
        begin
            r.op = OP_STEP;
            if ($urandom_range(0, 9) == 0)
                r.uniform = $urandom_range(0, 1) ? '1 : '0;
        end
        else if (kind < 72)
        begin
            r.op = OP_LOAD;
            if ($urandom_range(0, 9) != 0)
            begin
                r.row = IDX_W'($urandom_range(0, n - 1));
                r.col = IDX_W'($urandom_range(0, n - 1));
            end
            case ($urandom_range(0, 7))
                0: r.prob = '0;
                1: r.prob = 17'h10000;
                2: r.prob = '1;
                3: ;
                default: r.prob = PROB_W'($urandom_range(0, 131072 / n));
            endcase
        end
        else if (kind < 90)
        begin
            r.op = OP_SET;
            if ($urandom_range(0, 6) != 0)
                r.new_state = IDX_W'($urandom_range(0, n - 1));
        end
        else if (kind < 95)
        begin
            r.op = OP_RSVD;
        end
        return r;
    endfunction

    task automatic send_request(input chain_req_t r, input bit typed, input chain_res_t want);
        int gap;
        chain_res_t res;
        gap = sender_pauses ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.uniform, r.new_state, r.prob, r.col, r.row};
        s_tuser  <= r.op;
        do @(posedge clk); while (!s_tready);
        res = apply_request(r);
        pending_results.push_back(typed ? want : res);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // optional write of num_states, always followed by a readback
    task automatic access_states_reg(input bit do_write, input logic [NUM_W-1:0] value);
        if (do_write)
        begin
            repeat (SETTLE) @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= '0;
            pwdata  <= APB_DW'(value);
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            states_cfg = value;
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== APB_DW'(states_cfg))
        begin
            $error("num_states readback mismatch: expected %0d, actual %0d", states_cfg, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : result_monitor
        int stall;
        chain_res_t want;
        forever
        begin
            stall = receiver_stalls ? $urandom_range(0, 11) : 0;
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_results.size() == 0)
            begin
                $error("unexpected transfer: current_state %0d, error %0d", m_tdata[3:0], m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.state)
                begin
                    $error("current_state mismatch: expected %0d, actual %0d",
                           want.state, m_tdata[IDX_W-1:0]);
                    mismatch_count++;
                end
                if (m_tuser !== want.err)
                begin
                    $error("error mismatch: expected %0d, actual %0d", want.err, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("markov_chain_state_sampler regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        chain_req_t r;
        chain_res_t want;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        access_states_reg(1'b0, '0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].states != states_cfg)
            begin
                drain_results();
                access_states_reg(1'b1, directed_rows[i].states);
            end
            r.op = directed_rows[i].op;
            r.row = directed_rows[i].row;
            r.col = directed_rows[i].col;
            r.prob = directed_rows[i].prob;
            r.new_state = directed_rows[i].new_state;
            r.uniform = directed_rows[i].uniform;
            want.state = directed_rows[i].exp_state;
            want.err = directed_rows[i].exp_err;
            send_request(r, directed_rows[i].typed, want);
        end
        drain_results();

        // fill every entry so later steps never touch unwritten memory
        access_states_reg(1'b1, NUM_W'(MAX_STATES));
        for (int i = 0; i < MAX_STATES; i++)
        begin
            for (int j = 0; j < MAX_STATES; j++)
            begin
                r = random_request();
                r.op = OP_LOAD;
                r.row = IDX_W'(i);
                r.col = IDX_W'(j);
                r.prob = PROB_W'($urandom_range(0, 8191));
                send_request(r, 1'b0, want);
            end
        end
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            access_states_reg(1'b1, NUM_W'(phase_states[p]));
            sender_pauses = (p % 4 != 0);
            receiver_stalls = (p % 4 != 0) && (p % 4 != 3);
            if (p == 2)
                hold_cycles = 400;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 5 && k == PHASE_ITEMS / 2)
                    drain_results();
                send_request(random_request(), 1'b0, want);
            end
            drain_results();
        end

        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("markov_chain_state_sampler regression: pass");
        else
            $display("markov_chain_state_sampler regression: fail");
        $finish;
    end

endmodule

[markov_chain_state_sampler.f]
src/mcss_pkg.sv
src/mcss_ram.sv
src/mcss_ctrl.sv
src/mcss_datapath.sv
src/markov_chain_state_sampler.sv
sim/tb_top.sv
